>>> rtl/polar_to_complex_hamming_window_core_macros.svh
// assertion macros used by the top-level rtl file
`ifndef POLAR_TO_COMPLEX_HAMMING_WINDOW_CORE_MACROS_SVH
`define POLAR_TO_COMPLEX_HAMMING_WINDOW_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define P2C_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define P2C_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/p2c_pkg.sv
// shared constants and types for the polar to windowed complex core
package p2c_pkg;

  // field widths
  localparam int MAG_W  = 16;
  localparam int PH_W   = 16;
  localparam int BIN_W  = 12;
  localparam int OUT_W  = 18;
  localparam int ANG_W  = 32;

  // register map
  localparam int          ADDR_W           = 3;
  localparam logic [2:0]  ADDR_WINDOW_STEP = 3'h0;
  localparam logic [31:0] WINDOW_STEP_RST  = 32'd2098176;

  // default bin count bound
  localparam int MAX_BINS_DEF = 4096;

  // angle and series constants
  localparam logic [33:0] PI_Q32      = 34'h3243F6A89;
  localparam logic [33:0] RAD_TO_TURN = 34'h145F306DD;
  localparam logic [29:0] OCTANT      = 30'h20000000;
  localparam logic [30:0] QUARTER     = 31'h40000000;
  localparam int          NTERMS      = 7;
  // sine/cosine unit: fold, square, three stages per term, quadrant
  localparam int          SC_LAT      = 3 * NTERMS + 3;

  // window and rounding constants
  localparam logic signed [63:0] HAM_A   = 64'sd579820585;
  localparam logic signed [63:0] HAM_B   = 64'sd493921239;
  localparam logic signed [63:0] RND_14  = 64'sd8192;
  localparam logic signed [63:0] RND_30  = 64'sd536870912;
  localparam logic signed [63:0] RND_46  = 64'sd35184372088832;
  localparam logic signed [63:0] OUT_MAX = 64'sd131071;
  localparam logic signed [63:0] OUT_MIN = -64'sd131072;

  // cosine and sine pair, Q30
  typedef struct packed {
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } sc_t;

endpackage

>>> rtl/p2c_sincos.sv
// pipelined Taylor-series sine and cosine of a 32-bit turn angle
module p2c_sincos (
  input  logic           clk,
  input  logic           ce,
  input  logic [31:0]    angle,
  output p2c_pkg::sc_t   result
);

  localparam int NT  = p2c_pkg::NTERMS;
  localparam int NST = 3 * NT;

  // fold stage
  logic [29:0] r_in;
  logic [29:0] r_fold;
  logic        fold_in;
  logic [63:0] x_prod;
  logic [29:0] x0;
  logic [1:0]  quad0;
  logic        fold0;

  always_comb begin
    r_in    = angle[29:0];
    fold_in = (r_in > p2c_pkg::OCTANT);
    r_fold  = fold_in ? 30'(p2c_pkg::QUARTER - {1'b0, r_in}) : r_in;
    x_prod  = 64'(r_fold) * 64'(p2c_pkg::PI_Q32);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x0    <= x_prod[62:33];
      quad0 <= angle[31:30];
      fold0 <= fold_in;
    end
  end

  // square stage and series seeds
  logic [59:0]        x2_prod;
  logic [29:0]        x2_p   [NST+1];
  logic [1:0]         quad_p [NST+1];
  logic               fold_p [NST+1];
  logic [30:0]        t_p    [2][NST+1];
  logic signed [31:0] acc_p  [2][NST+1];
  logic [30:0]        q0_r   [2][NT];

  assign x2_prod = 60'(x0) * 60'(x0);

  always_ff @(posedge clk) begin
    if (ce) begin
      x2_p[0]     <= x2_prod[59:30];
      quad_p[0]   <= quad0;
      fold_p[0]   <= fold0;
      t_p[0][0]   <= 31'(x0);
      acc_p[0][0] <= 32'(x0);
      t_p[1][0]   <= p2c_pkg::QUARTER;
      acc_p[1][0] <= 32'(p2c_pkg::QUARTER);
    end
  end

  // control travels beside the terms
  for (genvar j = 0; j < NST; j++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (ce) begin
        x2_p[j+1]   <= x2_p[j];
        quad_p[j+1] <= quad_p[j];
        fold_p[j+1] <= fold_p[j];
      end
    end
  end

  // one term: multiply by x^2, divide by n(n+1), accumulate
  for (genvar ch = 0; ch < 2; ch++) begin : g_ch
    for (genvar i = 0; i < NT; i++) begin : g_term
      localparam int unsigned N     = (ch == 0) ? 2 * i + 2 : 2 * i + 1;
      localparam int unsigned D     = N * (N + 1);
      localparam logic [31:0] RECIP = 32'((64'd1 << 32) / D);
      localparam int          J     = 3 * i;
      localparam bit          SUB   = ((i % 2) == 0);

      logic [61:0] vx;
      logic [62:0] qx;
      logic [30:0] rem;
      logic [30:0] q;

      always_comb begin
        vx  = 62'(t_p[ch][J]) * 62'(x2_p[J]);
        qx  = 63'(t_p[ch][J+1]) * 63'(RECIP);
        rem = t_p[ch][J+2] - 31'(q0_r[ch][i] * 31'(D));
        q   = q0_r[ch][i] + 31'(rem >= 31'(D));
      end

      always_ff @(posedge clk) begin
        if (ce) begin
          t_p[ch][J+1]   <= vx[60:30];
          acc_p[ch][J+1] <= acc_p[ch][J];
          t_p[ch][J+2]   <= t_p[ch][J+1];
          q0_r[ch][i]    <= qx[62:32];
          acc_p[ch][J+2] <= acc_p[ch][J+1];
          t_p[ch][J+3]   <= q;
          if (SUB) begin
            acc_p[ch][J+3] <= acc_p[ch][J+2] - $signed({1'b0, q});
          end else begin
            acc_p[ch][J+3] <= acc_p[ch][J+2] + $signed({1'b0, q});
          end
        end
      end
    end
  end

  // undo octant fold and place in quadrant
  logic signed [31:0] s_f;
  logic signed [31:0] c_f;
  p2c_pkg::sc_t       res_next;

  always_comb begin
    s_f = fold_p[NST] ? acc_p[1][NST] : acc_p[0][NST];
    c_f = fold_p[NST] ? acc_p[0][NST] : acc_p[1][NST];
    case (quad_p[NST])
      2'd0: begin
        res_next.cos_v = c_f;
        res_next.sin_v = s_f;
      end
      2'd1: begin
        res_next.cos_v = -s_f;
        res_next.sin_v = c_f;
      end
      2'd2: begin
        res_next.cos_v = -c_f;
        res_next.sin_v = -s_f;
      end
      default: begin
        res_next.cos_v = s_f;
        res_next.sin_v = -c_f;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      result <= res_next;
    end
  end

endmodule

>>> rtl/polar_to_complex_hamming_window_core.sv
// top level: polar bin to Hamming-windowed complex value
//
// channel   direction  contents
// s_axis    in         tdata: magnitude, phase, bin_index; tlast: last_in
// m_axis    out        tdata: real_part, imag_part; tlast: last_out
// apb       in/out     window_step at byte address 0
//
// one word per clock sustained while the skid entry is empty; the pipeline runs from input to output register
// the depth is set by the sine/cosine units: three stages per series term
// reset clears valid bits and sets window_step to its default (N = 2048)
// a two-entry output register and skid stage part the sides; the pipeline
// halts only while the skid entry is held
`include "polar_to_complex_hamming_window_core_macros.svh"

module polar_to_complex_hamming_window_core #(
  parameter int MAX_BINS = p2c_pkg::MAX_BINS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // magnitude [15:0], phase [31:16], bin_index [43:32], zero [47:44]
  input  logic [47:0]                s_axis_tdata,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic                       s_axis_tlast,
  // real_part [17:0], imag_part [35:18], zero [39:36]
  output logic [39:0]                m_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic                       m_axis_tlast,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [p2c_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int SC  = p2c_pkg::SC_LAT;
  localparam int LAT = SC + 5;
  localparam int LST = LAT - 1;

  // config register
  logic [31:0] window_step;

  assign pready = 1'b1;
  assign prdata = (paddr == p2c_pkg::ADDR_WINDOW_STEP) ? window_step : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_step <= p2c_pkg::WINDOW_STEP_RST;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == p2c_pkg::ADDR_WINDOW_STEP)) begin
      window_step <= pwdata;
    end
  end

  // pipeline advance and valid bits
  logic           ce;
  logic [LAT-1:0] vld;
  logic           skid_valid;

  assign ce            = !skid_valid;
  assign s_axis_tready = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  // input stage: angles from phase and bin index
  logic [15:0]        mag_in;
  logic signed [15:0] ph_in;
  logic [11:0]        k_in;
  logic [11:0]        k_cl;
  logic signed [49:0] ph_prod;
  logic [49:0]        ph_rnd;
  logic [43:0]        w_prod;
  logic [31:0]        p_ang;
  logic [31:0]        w_ang;

  always_comb begin
    mag_in  = s_axis_tdata[15:0];
    ph_in   = $signed(s_axis_tdata[31:16]);
    k_in    = s_axis_tdata[43:32];
    k_cl    = (int'(k_in) >= MAX_BINS) ? 12'(MAX_BINS - 1) : k_in;
    ph_prod = 50'(ph_in) * $signed({16'd0, p2c_pkg::RAD_TO_TURN});
    ph_rnd  = 50'(ph_prod) + 50'h8000;
    w_prod  = 44'(k_cl) * 44'(window_step);
  end

  logic [15:0] mag_d  [SC+1];
  logic        last_d [SC+1];

  always_ff @(posedge clk) begin
    if (ce) begin
      p_ang     <= ph_rnd[47:16];
      w_ang     <= w_prod[31:0];
      mag_d[0]  <= mag_in;
      last_d[0] <= s_axis_tlast;
    end
  end

  for (genvar j = 0; j < SC; j++) begin : g_side
    always_ff @(posedge clk) begin
      if (ce) begin
        mag_d[j+1]  <= mag_d[j];
        last_d[j+1] <= last_d[j];
      end
    end
  end

  // sine and cosine of both angles
  p2c_pkg::sc_t p_sc;
  p2c_pkg::sc_t w_sc;

  p2c_sincos u_phase (
    .clk    (clk),
    .ce     (ce),
    .angle  (p_ang),
    .result (p_sc)
  );

  p2c_sincos u_window (
    .clk    (clk),
    .ce     (ce),
    .angle  (w_ang),
    .result (w_sc)
  );

  // window product, weight, scaled magnitude, rotation, rounding
  logic signed [63:0] hb;
  logic signed [31:0] w_wt;
  logic signed [63:0] mwp;
  logic signed [33:0] mw_c;
  logic signed [63:0] pr;
  logic signed [63:0] pi_p;
  logic signed [31:0] pc1, ps1, pc2, ps2;
  logic [15:0]        mag1;
  logic               last1, last2, last3, last4;
  logic signed [63:0] rr_c, ri_c;
  logic [17:0]        re_s, im_s;
  logic [17:0]        re4, im4;

  always_comb begin
    w_wt = 32'(p2c_pkg::HAM_A - ((hb + p2c_pkg::RND_30) >>> 30));
    mw_c = 34'((mwp + p2c_pkg::RND_14) >>> 14);
    rr_c = (pr + p2c_pkg::RND_46) >>> 46;
    ri_c = (pi_p + p2c_pkg::RND_46) >>> 46;
    if (rr_c > p2c_pkg::OUT_MAX) begin
      re_s = 18'(p2c_pkg::OUT_MAX);
    end else if (rr_c < p2c_pkg::OUT_MIN) begin
      re_s = 18'(p2c_pkg::OUT_MIN);
    end else begin
      re_s = 18'(rr_c);
    end
    if (ri_c > p2c_pkg::OUT_MAX) begin
      im_s = 18'(p2c_pkg::OUT_MAX);
    end else if (ri_c < p2c_pkg::OUT_MIN) begin
      im_s = 18'(p2c_pkg::OUT_MIN);
    end else begin
      im_s = 18'(ri_c);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      hb    <= p2c_pkg::HAM_B * 64'(w_sc.cos_v);
      pc1   <= p_sc.cos_v;
      ps1   <= p_sc.sin_v;
      mag1  <= mag_d[SC];
      last1 <= last_d[SC];
      mwp   <= $signed({48'd0, mag1}) * 64'(w_wt);
      pc2   <= pc1;
      ps2   <= ps1;
      last2 <= last1;
      pr    <= 64'(mw_c) * 64'(pc2);
      pi_p  <= 64'(mw_c) * 64'(ps2);
      last3 <= last2;
      re4   <= re_s;
      im4   <= im_s;
      last4 <= last3;
    end
  end

  // output register with skid entry
  logic        out_valid;
  logic [35:0] out_data;
  logic        out_last;
  logic [35:0] skid_data;
  logic        skid_last;
  logic        pop;
  logic        push;

  assign pop  = out_valid && m_axis_tready;
  assign push = vld[LST] && ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop || !out_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (pop || !out_valid) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop || !out_valid) begin
        out_data <= skid_data;
        out_last <= skid_last;
      end
    end else if (pop || !out_valid) begin
      out_data <= {im4, re4};
      out_last <= last4;
    end else if (push) begin
      skid_data <= {im4, re4};
      skid_last <= last4;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_data};
  assign m_axis_tlast  = out_last;

  // checks on the output buffering
  `P2C_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid word without output word")
  `P2C_ASSERT_NOW(a_skid_blocks_in, skid_valid, !s_axis_tready, "input taken while skid full")
  `P2C_ASSERT_NEXT(a_stall_keeps_tail, vld[LST] && !ce, vld[LST], "pipeline tail lost on stall")

endmodule

>>> bench/testbench.sv
// testbench for the polar to Hamming-windowed complex core
`timescale 1ns / 1ps

module testbench;

  localparam int    LATENCY     = 30;
  localparam int    RANDOM_BINS = 1050;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [33:0] PI_TURN  = 34'h3243F6A89;
  localparam logic [33:0] RAD_TURN = 34'h145F306DD;
  localparam longint WIN_A = 579820585;
  localparam longint WIN_B = 493921239;
  localparam longint Q30_ONE = 64'h40000000;

  typedef struct {
    logic [15:0] mag;
    logic [15:0] ph;
    logic [11:0] bin;
    logic        lst;
  } bin_word_t;

  typedef struct {
    logic [17:0] re;
    logic [17:0] im;
    logic        lst;
  } cplx_word_t;

  logic        clk;
  logic        rst;
  logic [47:0] s_axis_tdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic        s_axis_tlast;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [p2c_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] step_model;
  cplx_word_t  pending_cplx[$];
  int          errors;
  longint      cycles;

  polar_to_complex_hamming_window_core dut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // quarter-wave series evaluation of one turn-fraction angle, Q30
  function automatic void turn_sincos(input logic [31:0] a, output longint c_o,
                                      output longint s_o);
    logic [1:0]  quad;
    logic [31:0] r;
    logic        fold;
    logic [63:0] x, x2, t;
    longint      s, c, tmp;
    bit          neg;
    quad = a[31:30];
    r = {2'b0, a[29:0]};
    fold = r > 32'h20000000;
    if (fold) r = 32'h40000000 - r;
    x = (64'(r) * 64'(PI_TURN)) >> 33;
    x2 = (x * x) >> 30;
    s = longint'(x);
    t = x;
    neg = 1;
    for (int n = 2; n <= 14; n += 2) begin
      t = ((t * x2) >> 30) / 64'(n * (n + 1));
      s = neg ? s - longint'(t) : s + longint'(t);
      neg = !neg;
    end
    c = Q30_ONE;
    t = 64'(Q30_ONE);
    neg = 1;
    for (int n = 1; n <= 13; n += 2) begin
      t = ((t * x2) >> 30) / 64'(n * (n + 1));
      c = neg ? c - longint'(t) : c + longint'(t);
      neg = !neg;
    end
    if (fold) begin
      tmp = s;
      s = c;
      c = tmp;
    end
    case (quad)
      2'd0: begin c_o = c;  s_o = s;  end
      2'd1: begin c_o = -s; s_o = c;  end
      2'd2: begin c_o = -c; s_o = -s; end
      default: begin c_o = s; s_o = -c; end
    endcase
  endfunction

  function automatic logic [17:0] clip18(longint v);
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v[17:0];
  endfunction

  function automatic cplx_word_t windowed_cplx(bin_word_t b);
    cplx_word_t r;
    longint ph, pc, ps, wc, ws, w, mw;
    logic [63:0] prod;
    logic [31:0] pang, wang;
    ph = longint'($signed(b.ph));
    prod = 64'(ph) * 64'(RAD_TURN) + 64'h8000;
    pang = prod[47:16];
    wang = 32'(b.bin) * step_model;
    turn_sincos(pang, pc, ps);
    turn_sincos(wang, wc, ws);
    w = WIN_A - rnd_shift(WIN_B * wc, 30);
    mw = rnd_shift(longint'(b.mag) * w, 14);
    r.re = clip18(rnd_shift(mw * pc, 46));
    r.im = clip18(rnd_shift(mw * ps, 46));
    r.lst = b.lst;
    return r;
  endfunction

  // register write: setup then access
  task automatic apb_write(logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= p2c_pkg::ADDR_WINDOW_STEP; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    step_model = val;
  endtask

  // push one word, with a random burst gap
  task automatic send_bin(bin_word_t b);
    s_axis_tdata <= {4'b0, b.bin, b.ph, b.mag};
    s_axis_tlast <= b.lst;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pending_cplx.push_back(windowed_cplx(b));
    if ($urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_cplx.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic bin_word_t rand_bin();
    bin_word_t b;
    b.mag = 16'($urandom);
    if ($urandom_range(0, 3) == 0) b.mag = 16'hFFFF - 16'($urandom_range(0, 3));
    b.ph = 16'($urandom);
    b.bin = 12'($urandom);
    b.lst = $urandom_range(0, 15) == 0;
    return b;
  endfunction

  // receiver stalls in a rotating pattern
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ((cycles / 200) % 3 == 0) ? 1'b1 : ($urandom_range(0, 2) != 0);
  end

  // compare each output word with the oldest expectation
  always @(posedge clk) begin
    cplx_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_cplx.size() == 0) begin
        $display("%0t unexpected word %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_cplx.pop_front();
        if (m_axis_tdata[17:0] !== want.re) begin
          $display("%0t real_part expected %h actual %h", $time, want.re, m_axis_tdata[17:0]);
          errors++;
        end
        if (m_axis_tdata[35:18] !== want.im) begin
          $display("%0t imag_part expected %h actual %h", $time, want.im,
                   m_axis_tdata[35:18]);
          errors++;
        end
        if (m_axis_tlast !== want.lst) begin
          $display("%0t last_out expected %b actual %b", $time, want.lst, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // directed rows: magnitude, phase, bin, last
  bin_word_t directed[$] = '{
    '{16'd0,     16'h0000, 12'd0,    1'b0},
    '{16'hFFFF,  16'h0000, 12'd1023, 1'b0},
    '{16'hFFFF,  16'h6488, 12'd1023, 1'b0},
    '{16'hFFFF,  16'h9B78, 12'd1023, 1'b0},
    '{16'hFFFF,  16'h7FFF, 12'd0,    1'b1},
    '{16'hFFFF,  16'h8000, 12'd4095, 1'b0},
    '{16'd1,     16'h3244, 12'd2047, 1'b0},
    '{16'd12345, 16'hCDBC, 12'd500,  1'b1},
    '{16'h8000,  16'h1922, 12'd2048, 1'b0},
    '{16'h7FFF,  16'hFFFF, 12'd3000, 1'b0},
    '{16'hAAAA,  16'h5555, 12'hAAA,  1'b1},
    '{16'h5555,  16'hAAAA, 12'h555,  1'b0}
  };

  initial begin
    logic [31:0] steps[4];
    clk = 1'b0; rst = 1'b1;
    s_axis_tdata = '0; s_axis_tvalid = 1'b0; s_axis_tlast = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    step_model = p2c_pkg::WINDOW_STEP_RST;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset value of window_step, then directed rows
    foreach (directed[i]) send_bin(directed[i]);
    drain();

    // window step settings including extremes
    steps[0] = 32'd0;
    steps[1] = 32'hFFFFFFFF;
    steps[2] = 32'd1048832;
    steps[3] = $urandom;
    for (int p = 0; p < 4; p++) begin
      apb_write(steps[p]);
      for (int i = 0; i < RANDOM_BINS / 5; i++) send_bin(rand_bin());
      drain();
    end
    apb_write(p2c_pkg::WINDOW_STEP_RST);
    for (int i = 0; i < RANDOM_BINS / 5; i++) send_bin(rand_bin());
    drain();

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
